@@ design/gdp_pkg.sv @@
// ----------------------------------------------------------------------------
// gdp_pkg
// Shared types, formats and constants of the Gaussian posterior classifier.
// ----------------------------------------------------------------------------
package gdp_pkg;

  localparam int NUM_FEATURES_DEF = 16;
  localparam int NUM_CLASSES_DEF  = 8;

  localparam int DATA_W     = 16;   // table words and features
  localparam int D_W        = 17;   // feature minus mean, Q9.8
  localparam int A_W        = 31;   // series accumulator, Q1.30
  localparam int L_W        = 32;   // likelihood, Q1.31
  localparam int W_W        = 48;   // likelihood times prior
  localparam int Q_W        = 17;   // quotient bits of a posterior
  localparam int QSUM_W     = 64;   // quadratic form accumulator
  localparam int QS_W       = 52;   // quadratic form in Q.16
  localparam int Z_W        = 23;   // scaled exponent, Q.16
  localparam int CMD_AW     = 12;   // widest table address
  localparam int IDX_CMP_W  = 7;    // holds any index and NUM_FEATURES
  localparam int FIFO_DEPTH = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int EXP_STEPS  = 4;

  localparam logic [4:0] FEAT_CFG_RESET = 5'd16;
  localparam logic [3:0] CLS_CFG_RESET  = 4'd2;

  localparam logic [15:0]     LOG2E_HALF_Q16 = 16'd47274;
  localparam logic [QS_W-1:0] QS_LIMIT       = QS_W'(64 << 16);
  localparam logic [A_W-1:0]  ONE_Q30        = 31'd1073741824;
  localparam logic [A_W-1:0]  C1_Q30         = 31'd744261118;
  localparam logic [A_W-1:0]  C2_Q30         = 31'd257941247;
  localparam logic [A_W-1:0]  C3_Q30         = 31'd59597094;
  localparam logic [A_W-1:0]  C4_Q30         = 31'd10327387;

  typedef enum logic [1:0] {
    ACT_MEAN   = 2'd0,
    ACT_PREC   = 2'd1,
    ACT_PRIOR  = 2'd2,
    ACT_SAMPLE = 2'd3
  } act_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURES = 2'd0,
    CFG_CLASSES  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    act_e              act;
    logic [CMD_AW-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              last;
  } cmd_t;

  // horner coefficients after the leading c4 term
  function automatic logic [A_W-1:0] exp_coef(input logic [1:0] step);
    logic [A_W-1:0] c;
    unique case (step)
      2'd0: c = C3_Q30;
      2'd1: c = C2_Q30;
      2'd2: c = C1_Q30;
      2'd3: c = ONE_Q30;
      default: c = ONE_Q30;
    endcase
    return c;
  endfunction

endpackage

@@ design/gdp_ram.sv @@
// ----------------------------------------------------------------------------
// gdp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gdp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gdp_front.sv @@
// ----------------------------------------------------------------------------
// gdp_front
// Accepts input items, drops out-of-range loads, resolves table addresses
// and the feature slot of each sample, and queues commands for the back end.
// ----------------------------------------------------------------------------
module gdp_front import gdp_pkg::*; #(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1,
  parameter int CW = $clog2(NUM_CLASSES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [FW-1:0]            nf_m1_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic [5:0]               row_index_i,
  input  logic [5:0]               col_index_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  input  logic                     full_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  localparam int MA_W = $clog2(NUM_FEATURES * NUM_CLASSES);
  localparam int PA_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES * NUM_FEATURES) : 1;

  logic [FW-1:0] count_q, count_d;
  logic [FW-1:0] slot;
  logic          slot_last;
  logic          accept, keep;
  logic          row_f, col_f, row_c, col_c;
  logic [MA_W-1:0] mean_addr;
  logic [PA_W-1:0] prec_addr;
  act_e          act;

  assign act        = act_e'(action_i);
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign row_f = {1'b0, row_index_i} < IDX_CMP_W'(NUM_FEATURES);
  assign col_f = {1'b0, col_index_i} < IDX_CMP_W'(NUM_FEATURES);
  assign row_c = {1'b0, row_index_i} < IDX_CMP_W'(NUM_CLASSES);
  assign col_c = {1'b0, col_index_i} < IDX_CMP_W'(NUM_CLASSES);

  assign mean_addr = MA_W'(col_index_i[CW-1:0]) * MA_W'(NUM_FEATURES)
                   + MA_W'(row_index_i[FW-1:0]);
  assign prec_addr = PA_W'(row_index_i[FW-1:0]) * PA_W'(NUM_FEATURES)
                   + PA_W'(col_index_i[FW-1:0]);

  // a count left beyond the vector length after reconfiguration lands in the last slot
  assign slot      = (count_q > nf_m1_i) ? nf_m1_i : count_q;
  assign slot_last = (slot == nf_m1_i);

  always_comb begin
    cmd_o.act  = act;
    cmd_o.data = data_value_i;
    cmd_o.last = slot_last;
    unique case (act)
      ACT_MEAN: begin
        keep       = row_f && col_c;
        cmd_o.addr = CMD_AW'(mean_addr);
      end
      ACT_PREC: begin
        keep       = row_f && col_f;
        cmd_o.addr = CMD_AW'(prec_addr);
      end
      ACT_PRIOR: begin
        keep       = row_c;
        cmd_o.addr = CMD_AW'(row_index_i[CW-1:0]);
      end
      ACT_SAMPLE: begin
        keep       = 1'b1;
        cmd_o.addr = CMD_AW'(slot);
      end
      default: begin
        keep       = 1'b0;
        cmd_o.addr = '0;
      end
    endcase
  end

  assign push_o = accept && keep;

  always_comb begin
    count_d = count_q;
    if (accept && act == ACT_SAMPLE) begin
      count_d = slot_last ? '0 : slot + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ design/gdp_fifo.sv @@
// ----------------------------------------------------------------------------
// gdp_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module gdp_fifo import gdp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int AW = $clog2(DEPTH);

  cmd_t        entry_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW:0]   cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW + 1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? ((wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1)) : wptr_q;
    rptr_d = do_pop  ? ((rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1)) : rptr_q;
    cnt_d  = cnt_q + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ design/gdp_div.sv @@
// ----------------------------------------------------------------------------
// gdp_div
// Restoring divider for posterior normalization, one quotient bit a cycle.
// Expects num <= den, so the quotient of num * 2^16 / den fits 17 bits.
// ----------------------------------------------------------------------------
module gdp_div import gdp_pkg::*; #(
  parameter int NUM_W = W_W,
  parameter int DEN_W = W_W + 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o
);

  localparam int RW = DEN_W + 1;
  localparam int CNT_W = $clog2(Q_W);

  logic [RW-1:0]    rem_q, rem_d, rem_ext;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic             ge;

  // first step takes the integer bit without a shift
  assign rem_ext = (cnt_q == '0) ? rem_q : {rem_q[RW-2:0], 1'b0};
  assign ge      = rem_ext >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = RW'(num_i);
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? rem_ext - {1'b0, den_q} : rem_ext;
      quot_d = {quot_q[Q_W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ design/gdp_back.sv @@
// ----------------------------------------------------------------------------
// gdp_back
// Executes queued commands: table writes, feature buffering and, on a full
// vector, the per-class quadratic form, likelihood, weighting and posterior.
// ----------------------------------------------------------------------------
module gdp_back import gdp_pkg::*; #(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF,
  parameter int FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1,
  parameter int CW = $clog2(NUM_CLASSES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [FW-1:0] nf_m1_i,
  input  logic [CW-1:0] nc_m1_i,
  input  cmd_t          cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [2:0]    class_index_o,
  output logic [15:0]   posterior_o,
  output logic          last_class_o,
  output logic          no_evidence_o
);

  localparam int MA_W  = $clog2(NUM_FEATURES * NUM_CLASSES);
  localparam int PA_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES * NUM_FEATURES) : 1;
  localparam int SUM_W = W_W + $clog2(NUM_CLASSES);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIFF  = 10'b0000000010,
    S_ROW   = 10'b0000000100,
    S_COL   = 10'b0000001000,
    S_DRAIN = 10'b0000010000,
    S_EXP   = 10'b0000100000,
    S_WGT   = 10'b0001000000,
    S_DIV   = 10'b0010000000,
    S_DWAIT = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] c_q, c_d;
  logic [FW-1:0] i_q, i_d, j_q, j_d;
  logic [1:0]    k_q, k_d;
  logic          dv_q, dv_d, v1_q, v1_d, v2_q, v3_q, ov_q;
  logic          div_start, div_done, out_load, drained, row_load;
  logic [Q_W-1:0] div_quot;

  logic signed [DATA_W-1:0] fbuf_q  [NUM_FEATURES];
  logic [DATA_W-1:0]        prior_q [NUM_CLASSES];
  logic signed [D_W-1:0]    d_q     [NUM_FEATURES];
  logic [W_W-1:0]           w_q     [NUM_CLASSES];

  logic [FW-1:0]            didx_q, jq1_q, d_ra;
  logic signed [D_W-1:0]    d_rd, di_q;
  logic signed [32:0]       pa_q;
  logic signed [49:0]       pb_q;
  logic signed [QSUM_W-1:0] q_q;
  logic [QS_W-1:0]          qs;
  logic                     qneg_q, big_q;
  logic [Z_W-1:0]           z_q;
  logic [A_W-1:0]           a_q;
  logic [L_W-1:0]           lik;
  logic [W_W-1:0]           wgt;
  logic [SUM_W-1:0]         sum_q;
  logic [Q_W-1:0]           pq_q;
  logic [2:0]               cls_q;
  logic [15:0]              post_q;
  logic                     last_q, noev_q;

  logic                     mean_we, prec_we;
  logic [MA_W-1:0]          mean_raddr;
  logic [PA_W-1:0]          prec_raddr;
  logic [DATA_W-1:0]        mean_rdata, prec_rdata;

  gdp_ram #(.WIDTH(DATA_W), .DEPTH(NUM_FEATURES * NUM_CLASSES)) u_mean (
    .clk_i   (clk_i),
    .we_i    (mean_we),
    .waddr_i (cmd_i.addr[MA_W-1:0]),
    .wdata_i (cmd_i.data),
    .raddr_i (mean_raddr),
    .rdata_o (mean_rdata)
  );

  gdp_ram #(.WIDTH(DATA_W), .DEPTH(NUM_FEATURES * NUM_FEATURES)) u_prec (
    .clk_i   (clk_i),
    .we_i    (prec_we),
    .waddr_i (cmd_i.addr[PA_W-1:0]),
    .wdata_i (cmd_i.data),
    .raddr_i (prec_raddr),
    .rdata_o (prec_rdata)
  );

  gdp_div #(.NUM_W(W_W), .DEN_W(SUM_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (w_q[c_q]),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign mean_raddr = MA_W'(c_q) * MA_W'(NUM_FEATURES) + MA_W'(i_q);
  assign prec_raddr = PA_W'(i_q) * PA_W'(NUM_FEATURES) + PA_W'(j_q);

  assign mean_we = cmd_pop_o && cmd_i.act == ACT_MEAN;
  assign prec_we = cmd_pop_o && cmd_i.act == ACT_PREC;

  assign drained  = !v1_q && !v2_q && !v3_q;
  assign row_load = (state_q == S_ROW) && !dv_q && !v1_q;

  // single read port on the difference vector
  assign d_ra = v1_q ? jq1_q : i_q;
  assign d_rd = d_q[d_ra];

  assign qs  = q_q[QSUM_W-1:12];
  assign lik = qneg_q ? {1'b1, {(L_W - 1){1'b0}}}
             : big_q  ? '0
             : ({a_q, 1'b0} >> z_q[Z_W-1:16]);
  assign wgt = W_W'(lik) * W_W'(prior_q[c_q]);

  always_comb begin
    state_d   = state_q;
    c_d       = c_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    dv_d      = 1'b0;
    v1_d      = 1'b0;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.act == ACT_SAMPLE && cmd_i.last) begin
            state_d = S_DIFF;
            c_d     = '0;
            i_d     = '0;
          end
        end
      end
      S_DIFF: begin
        dv_d = 1'b1;
        if (i_q == nf_m1_i) begin
          i_d     = '0;
          state_d = S_ROW;
        end else begin
          i_d = i_q + FW'(1);
        end
      end
      S_ROW: begin
        if (!dv_q && !v1_q) begin
          j_d     = '0;
          state_d = S_COL;
        end
      end
      S_COL: begin
        v1_d = 1'b1;
        if (j_q == nf_m1_i) begin
          j_d = '0;
          if (i_q == nf_m1_i) begin
            state_d = S_DRAIN;
          end else begin
            i_d     = i_q + FW'(1);
            state_d = S_ROW;
          end
        end else begin
          j_d = j_q + FW'(1);
        end
      end
      S_DRAIN: begin
        if (drained) begin
          k_d     = '0;
          state_d = S_EXP;
        end
      end
      S_EXP: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'(EXP_STEPS - 1)) begin
          state_d = S_WGT;
        end
      end
      S_WGT: begin
        if (c_q == nc_m1_i) begin
          c_d     = '0;
          state_d = S_DIV;
        end else begin
          c_d     = c_q + CW'(1);
          i_d     = '0;
          state_d = S_DIFF;
        end
      end
      S_DIV: begin
        if (sum_q == '0) begin
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || out_ready_i) begin
          out_load = 1'b1;
          if (c_q == nc_m1_i) begin
            state_d = S_IDLE;
          end else begin
            c_d     = c_q + CW'(1);
            state_d = S_DIV;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.act == ACT_PRIOR) begin
      prior_q[cmd_i.addr[CW-1:0]] <= cmd_i.data;
    end
    if (cmd_pop_o && cmd_i.act == ACT_SAMPLE) begin
      fbuf_q[cmd_i.addr[FW-1:0]] <= cmd_i.data;
    end
    didx_q <= i_q;
    jq1_q  <= j_q;
    if (dv_q) begin
      d_q[didx_q] <= {fbuf_q[didx_q][DATA_W-1], fbuf_q[didx_q]}
                   - {mean_rdata[DATA_W-1], mean_rdata};
    end
    if (row_load) begin
      di_q <= d_rd;
    end
    // p[i][j] * d[j], then times d[i], then accumulate
    if (v1_q) begin
      pa_q <= 33'($signed(prec_rdata) * d_rd);
    end
    if (v2_q) begin
      pb_q <= 50'(pa_q * di_q);
    end
    if (state_q == S_DIFF) begin
      q_q <= '0;
    end else if (v3_q) begin
      q_q <= q_q + QSUM_W'(pb_q);
    end
    if (state_q == S_DRAIN && drained) begin
      qneg_q <= q_q[QSUM_W-1] || (q_q == '0);
      big_q  <= qs > QS_LIMIT;
      z_q    <= Z_W'((39'(qs[Z_W-1:0]) * 39'(LOG2E_HALF_Q16)) >> 16);
      a_q    <= C4_Q30;
    end
    if (state_q == S_EXP) begin
      a_q <= exp_coef(k_q) - A_W'((47'(a_q) * 47'(z_q[15:0])) >> 16);
    end
    if (state_q == S_IDLE) begin
      sum_q <= '0;
    end else if (state_q == S_WGT) begin
      w_q[c_q] <= wgt;
      sum_q    <= sum_q + SUM_W'(wgt);
    end
    if (div_done) begin
      pq_q <= div_quot;
    end
    if (out_load) begin
      cls_q  <= 3'(c_q);
      noev_q <= (sum_q == '0);
      last_q <= (c_q == nc_m1_i);
      post_q <= (sum_q == '0) ? '0 : (pq_q[Q_W-1] ? 16'hFFFF : pq_q[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      c_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      dv_q    <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      dv_q    <= dv_d;
      v1_q    <= v1_d;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ov_q;
  assign class_index_o = cls_q;
  assign posterior_o   = post_q;
  assign last_class_o  = last_q;
  assign no_evidence_o = noev_q;

  a_drained_before_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXP |-> !v1_q && !v2_q && !v3_q)
    else $error("quadratic form pipeline not empty at exponent stage");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DWAIT)
    else $error("divider finished outside its wait state");

  a_noev_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && noev_q |-> post_q == '0)
    else $error("posterior nonzero without evidence");

  a_diff_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIFF |-> $past(state_q) == S_IDLE || $past(state_q) == S_DIFF
                          || $past(state_q) == S_WGT)
    else $error("class evaluation entered from an unexpected state");

endmodule

@@ design/gaussian_lda_posterior.sv @@
// ----------------------------------------------------------------------------
// gaussian_lda_posterior
// Shared-covariance Gaussian classifier giving normalized class posteriors.
// ----------------------------------------------------------------------------
// The back end executes load items only while it is idle. The sample that
// completes a vector starts an evaluation that, for nf active features and nc
// active classes, computes each class's quadratic form and likelihood through
// the single precision-table read port feeding one multiply chain, then divides
// each weighted likelihood by the sum of all of them in the bit-serial divider
// to give the posteriors. The two-entry command queue takes in items that arrive
// while the back end works until it is full, and a results register lets the
// next posterior be prepared while the last one waits to be taken.
// ----------------------------------------------------------------------------
module gaussian_lda_posterior import gdp_pkg::*; #(
  parameter int NUM_FEATURES = NUM_FEATURES_DEF,
  parameter int NUM_CLASSES  = NUM_CLASSES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic [5:0]               row_index_i,
  input  logic [5:0]               col_index_i,
  input  logic signed [DATA_W-1:0] data_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               class_index_o,
  output logic [15:0]              posterior_o,
  output logic                     last_class_o,
  output logic                     no_evidence_o
);

  localparam int FW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int CW = $clog2(NUM_CLASSES);

  logic [4:0] feat_q, feat_d;
  logic [3:0] cls_q, cls_d;
  logic [IDX_CMP_W-1:0] feat_ext, cls_ext, nf_sat, nc_sat;
  logic [FW-1:0] nf_m1;
  logic [CW-1:0] nc_m1;
  logic          cfg_write;

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    feat_d = feat_q;
    cls_d  = cls_q;
    if (cfg_write && cfg_index_i == CFG_FEATURES) begin
      feat_d = cfg_data_i[4:0];
    end
    if (cfg_write && cfg_index_i == CFG_CLASSES) begin
      cls_d = cfg_data_i[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_q <= FEAT_CFG_RESET;
      cls_q  <= CLS_CFG_RESET;
    end else begin
      feat_q <= feat_d;
      cls_q  <= cls_d;
    end
  end

  // registers saturate to their usable ranges
  assign feat_ext = IDX_CMP_W'(feat_q);
  assign cls_ext  = IDX_CMP_W'(cls_q);
  assign nf_sat   = (feat_ext == '0) ? IDX_CMP_W'(1)
                  : (feat_ext > IDX_CMP_W'(NUM_FEATURES)) ? IDX_CMP_W'(NUM_FEATURES) : feat_ext;
  assign nc_sat   = (cls_ext < IDX_CMP_W'(2)) ? IDX_CMP_W'(2)
                  : (cls_ext > IDX_CMP_W'(NUM_CLASSES)) ? IDX_CMP_W'(NUM_CLASSES) : cls_ext;
  assign nf_m1    = FW'(nf_sat - IDX_CMP_W'(1));
  assign nc_m1    = CW'(nc_sat - IDX_CMP_W'(1));

  gdp_front #(.NUM_FEATURES(NUM_FEATURES), .NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .nf_m1_i      (nf_m1),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .data_value_i (data_value_i),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  gdp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  gdp_back #(.NUM_FEATURES(NUM_FEATURES), .NUM_CLASSES(NUM_CLASSES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nf_m1_i       (nf_m1),
    .nc_m1_i       (nc_m1),
    .cmd_i         (cmd_out),
    .cmd_empty_i   (empty),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .class_index_o (class_index_o),
    .posterior_o   (posterior_o),
    .last_class_o  (last_class_o),
    .no_evidence_o (no_evidence_o)
  );

endmodule

@@ bench/gaussian_lda_posterior_test.sv @@
// ----------------------------------------------------------------------------
// gaussian_lda_posterior_test
// Self-checking bench for the Gaussian posterior classifier: fills the mean,
// precision and prior tables, runs directed corner vectors, then random vector
// traffic over several feature and class counts, mostly with both handshakes
// idling at random. Every posterior is checked against a bit-exact predictor.
// ----------------------------------------------------------------------------
module gaussian_lda_posterior_test;
  import gdp_pkg::*;

  localparam int NF_MAX     = 16;
  localparam int NC_MAX     = 8;
  localparam int SETTLE     = 3000;   // one full 16 x 8 evaluation plus margin
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  cls;
    logic [15:0] post;
    logic        last;
    logic        noev;
  } posterior_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               action_i = '0;
  logic [5:0]               row_index_i = '0;
  logic [5:0]               col_index_i = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [2:0]               class_index_o;
  logic [15:0]              posterior_o;
  logic                     last_class_o;
  logic                     no_evidence_o;

  // predictor state
  logic signed [15:0] mean_tab [NC_MAX][NF_MAX];
  logic signed [15:0] prec_tab [NF_MAX][NF_MAX];
  logic [15:0]        prior_tab [NC_MAX];
  logic signed [15:0] feat_buf [NF_MAX];
  int unsigned        feat_count;
  logic [4:0]         cfg_features;
  logic [3:0]         cfg_classes;

  posterior_t  posterior_q[$];
  int unsigned tx_idle_pct, rx_idle_pct;
  int unsigned errors, n_items, n_vectors, n_results, n_cfg, idle_cycles;

  gaussian_lda_posterior i_dut (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // exp(-q/2) in Q1.31 through the base-2 series
  function automatic logic [31:0] likelihood(input longint q);
    logic [63:0] qs, z, f, acc, m;
    int unsigned n;
    if (q <= 0) return 32'h8000_0000;
    qs = 64'(q) >> 12;
    if (qs > (64'd64 << 16)) return 32'd0;
    z   = (qs * 64'(LOG2E_HALF_Q16)) >> 16;
    n   = int'(z >> 16);
    f   = z & 64'hFFFF;
    acc = 64'(C4_Q30);
    acc = 64'(C3_Q30) - ((acc * f) >> 16);
    acc = 64'(C2_Q30) - ((acc * f) >> 16);
    acc = 64'(C1_Q30) - ((acc * f) >> 16);
    m   = 64'(ONE_Q30) - ((acc * f) >> 16);
    if (n >= 40) return 32'd0;
    return 32'((m << 1) >> n);
  endfunction

  task automatic predict_posteriors(input int nf, input int nc);
    longint      d [NF_MAX];
    logic [63:0] w [NC_MAX];
    logic [63:0] sum, p;
    longint      q;
    posterior_t  r;
    sum = '0;
    for (int c = 0; c < nc; c++) begin
      q = 0;
      for (int i = 0; i < nf; i++) d[i] = longint'(feat_buf[i]) - longint'(mean_tab[c][i]);
      for (int i = 0; i < nf; i++)
        for (int j = 0; j < nf; j++) q += d[i] * d[j] * longint'(prec_tab[i][j]);
      w[c] = 64'(likelihood(q)) * 64'(prior_tab[c]);
      sum += w[c];
    end
    for (int c = 0; c < nc; c++) begin
      p = '0;
      if (sum != 0) begin
        p = (w[c] << 16) / sum;
        if (p > 64'd65535) p = 64'd65535;
      end
      r.cls  = 3'(c);
      r.post = 16'(p);
      r.last = (c == nc - 1);
      r.noev = (sum == 0);
      posterior_q.insert(posterior_q.size(), r);
    end
    n_vectors++;
  endtask

  task automatic predict_item(input act_e act, input int row, input int col,
                              input logic [15:0] val);
    int nf, nc, idx;
    nf = (cfg_features < 1) ? 1 : (cfg_features > NF_MAX) ? NF_MAX : int'(cfg_features);
    nc = (cfg_classes < 2) ? 2 : (cfg_classes > NC_MAX) ? NC_MAX : int'(cfg_classes);
    case (act)
      ACT_MEAN: if (row < NF_MAX && col < NC_MAX) mean_tab[col][row] = val;
      ACT_PREC: if (row < NF_MAX && col < NF_MAX) prec_tab[row][col] = val;
      ACT_PRIOR: if (row < NC_MAX) prior_tab[row] = val;
      default: begin
        idx = (feat_count >= nf) ? nf - 1 : int'(feat_count);
        feat_buf[idx] = val;
        if (idx + 1 >= nf) begin
          feat_count = 0;
          predict_posteriors(nf, nc);
        end else begin
          feat_count = idx + 1;
        end
      end
    endcase
  endtask

  task automatic send_item(input act_e act, input int row, input int col,
                           input logic [15:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    row_index_i  <= 6'(row);
    col_index_i  <= 6'(col);
    data_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(act, row, col, val);
    n_items++;
  endtask

  // hold off until every posterior is out and the back end has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (posterior_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FEATURES) cfg_features = val;
    else cfg_classes = 4'(val);
    n_cfg++;
  endtask

  task automatic set_shape(input logic [4:0] nf, input logic [3:0] nc);
    drain();
    write_cfg(CFG_FEATURES, nf);
    write_cfg(CFG_CLASSES, 5'(nc));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] sane_prec(input int i, input int j);
    return (i == j) ? 16'($urandom_range(4096, 256)) : 16'(int'($urandom_range(512)) - 256);
  endfunction

  task automatic test_fill_tables();
    for (int c = 0; c < NC_MAX; c++)
      for (int f = 0; f < NF_MAX; f++)
        send_item(ACT_MEAN, f, c, 16'(int'($urandom_range(2048)) - 1024));
    for (int i = 0; i < NF_MAX; i++)
      for (int j = 0; j < NF_MAX; j++) send_item(ACT_PREC, i, j, sane_prec(i, j));
    for (int c = 0; c < NC_MAX; c++) send_item(ACT_PRIOR, c, 0, 16'($urandom_range(65535, 1)));
    // one full vector at the reset shape writes every feature slot
    for (int f = 0; f < NF_MAX; f++) send_item(ACT_SAMPLE, 0, 0, mean_tab[0][f]);
  endtask

  task automatic test_count_beyond();
    for (int f = 0; f < 5; f++) send_item(ACT_SAMPLE, 0, 0, 16'($urandom_range(511)));
    set_shape(5'd3, 4'd3);
    send_item(ACT_SAMPLE, 0, 0, 16'($urandom_range(511)));
  endtask

  task automatic test_corners();
    set_shape(5'd2, 4'd2);
    // full-scale difference against full-scale precision
    send_item(ACT_PREC, 0, 0, 16'h7FFF);
    send_item(ACT_MEAN, 0, 0, 16'h8000);
    send_item(ACT_MEAN, 0, 1, 16'h7FFF);
    send_item(ACT_SAMPLE, 0, 0, 16'h7FFF);
    send_item(ACT_SAMPLE, 0, 0, 16'h8000);
    // negative definite precision gives a non-positive form
    send_item(ACT_PREC, 0, 0, 16'h8000);
    send_item(ACT_PREC, 0, 1, 16'h0000);
    send_item(ACT_PREC, 1, 0, 16'h0000);
    send_item(ACT_PREC, 1, 1, 16'h8000);
    send_item(ACT_SAMPLE, 0, 0, 16'hFFFF);
    send_item(ACT_SAMPLE, 0, 0, 16'h0000);
    // one class carries all the weight, posterior saturates
    send_item(ACT_PRIOR, 0, 0, 16'hFFFF);
    send_item(ACT_PRIOR, 1, 0, 16'h0000);
    send_item(ACT_SAMPLE, 0, 0, 16'h0100);
    send_item(ACT_SAMPLE, 0, 0, 16'hFF00);
    // all priors zero, no evidence
    send_item(ACT_PRIOR, 0, 0, 16'h0000);
    send_item(ACT_SAMPLE, 0, 0, 16'h5555);
    send_item(ACT_SAMPLE, 0, 0, 16'hAAAA);
    // loads outside the tables leave them untouched
    send_item(ACT_MEAN, 63, 0, 16'hFFFF);
    send_item(ACT_MEAN, 0, 63, 16'hFFFF);
    send_item(ACT_PREC, 0, 63, 16'hFFFF);
    send_item(ACT_PRIOR, 63, 63, 16'hFFFF);
    for (int c = 0; c < 2; c++) send_item(ACT_PRIOR, c, 0, 16'($urandom_range(65535, 1)));
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) send_item(ACT_PREC, i, j, sane_prec(i, j));
  endtask

  task automatic test_random_traffic();
    logic [4:0] nf_list [9] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd2, 5'd4, 5'd5, 5'd7};
    logic [3:0] nc_list [9] = '{4'd2, 4'd8, 4'd15, 4'd1, 4'd5, 4'd8, 4'd3, 4'd0, 4'd8};
    int start, nf, cls, row, col;
    act_e act;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph / 3)
        0: begin tx_idle_pct = 25; rx_idle_pct = 81; end
        1: begin tx_idle_pct = 81; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      set_shape(nf_list[ph], nc_list[ph]);
      nf = (nf_list[ph] < 1) ? 1 : (nf_list[ph] > NF_MAX) ? NF_MAX : int'(nf_list[ph]);
      start = n_items;
      while (n_items - start < 3) begin
        if ($urandom_range(99) < 85) begin
          // a vector drawn around one class mean
          cls = $urandom_range(NC_MAX - 1);
          for (int f = 0; f < nf; f++)
            send_item(ACT_SAMPLE, 0, 0,
                      16'(int'(mean_tab[cls][f]) + int'($urandom_range(512)) - 256));
        end else begin
          act = act_e'($urandom_range(3));
          row = $urandom_range(63);
          col = $urandom_range(63);
          if ($urandom_range(1) == 0) begin
            row = row % NF_MAX;
            col = col % NC_MAX;
          end
          send_item(act, row, col, (act == ACT_PREC && $urandom_range(3) != 0) ?
                    sane_prec(row, col) : 16'($urandom));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      n_results++;
      if (posterior_q.size() == 0) begin
        report($sformatf("unexpected posterior class %0d", class_index_o));
      end else begin
        posterior_t e;
        e = posterior_q.pop_front();
        if (class_index_o !== e.cls)
          report($sformatf("class %0d, want %0d", class_index_o, e.cls));
        if (posterior_o !== e.post)
          report($sformatf("class %0d posterior %0d, want %0d", e.cls, posterior_o, e.post));
        if (last_class_o !== e.last)
          report($sformatf("class %0d last %b, want %b", e.cls, last_class_o, e.last));
        if (no_evidence_o !== e.noev)
          report($sformatf("class %0d no_evidence %b, want %b", e.cls, no_evidence_o, e.noev));
      end
    end
  end

  // cycles without any transfer on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout, %0d posteriors outstanding", posterior_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0; n_items = 0; n_vectors = 0; n_results = 0; n_cfg = 0; idle_cycles = 0;
    feat_count   = 0;
    cfg_features = FEAT_CFG_RESET;
    cfg_classes  = CLS_CFG_RESET;
    tx_idle_pct  = 25;
    rx_idle_pct  = 81;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_tables();
    test_count_beyond();
    test_corners();
    test_random_traffic();
    drain();
    $display("covered %0d items, %0d vectors, %0d posteriors, %0d register writes",
             n_items, n_vectors, n_results, n_cfg);
    $display("shapes from 1 to 16 features and 2 to 8 classes, incl. clamped settings");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gdp_pkg.sv
design/gdp_ram.sv
design/gdp_front.sv
design/gdp_fifo.sv
design/gdp_div.sv
design/gdp_back.sv
design/gaussian_lda_posterior.sv
bench/gaussian_lda_posterior_test.sv
